FILE: design/e8c_pkg.sv
// ----------------------------------------------------------------------------
// e8c_pkg
// Shared types, constants and opcode helpers of the 8-bit execute core.
// ----------------------------------------------------------------------------
package e8c_pkg;

	localparam int QDEPTH = 4;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_EXEC  = 2'd2;

	localparam logic [15:0] SP_RESET = 16'hFFFE;
	localparam logic [15:0] PC_RESET = 16'h0100;

	// flag nibble positions: Z N H C
	localparam int FZ = 3;
	localparam int FN = 2;
	localparam int FH = 1;
	localparam int FC = 0;

	localparam logic [7:0] OPC_HALT      = 8'h76;
	localparam logic [7:0] OPC_LD_A16_SP = 8'h08;
	localparam logic [7:0] OPC_MAIN_LO   = 8'h40;
	localparam logic [7:0] OPC_MAIN_HI   = 8'hBF;
	localparam logic [7:0] OPC_UNK_LO    = 8'h30;

	localparam logic [2:0] CODE_MEM = 3'd6;
	localparam logic [2:0] CODE_A   = 3'd7;

	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBC = 3'd3;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_XOR = 3'd5;
	localparam logic [2:0] ALU_OR  = 3'd6;
	localparam logic [2:0] ALU_CP  = 3'd7;

	typedef enum logic [1:0] {
		CLS_WRITE,
		CLS_READ,
		CLS_EXEC,
		CLS_NONE
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [15:0] address;
		logic [7:0]  data;
	} item_t;

	// immediate bytes following the opcode
	function automatic logic [1:0] imm_len(input logic [7:0] opc);
		logic [1:0] n;
		n = 2'd0;
		if (opc < OPC_UNK_LO) begin
			case (opc[3:0])
				4'h1: n = 2'd2;
				4'h6, 4'hE: n = 2'd1;
				4'h0: n = (opc[5:4] == 2'd2) ? 2'd1 : 2'd0;
				4'h8: n = (opc[5:4] == 2'd0) ? 2'd2 : ((opc[5:4] == 2'd1) ? 2'd1 : 2'd0);
				default: n = 2'd0;
			endcase
		end
		return n;
	endfunction

	// opcode takes an operand byte from memory
	function automatic logic mem_rd(input logic [7:0] opc);
		logic r;
		r = 1'b0;
		if (opc >= OPC_MAIN_LO && opc <= OPC_MAIN_HI)
			r = (opc[2:0] == CODE_MEM) && (opc != OPC_HALT);
		else if (opc < OPC_UNK_LO)
			r = (opc[3:0] == 4'hA);
		return r;
	endfunction

	function automatic logic [7:0] pick_r(input logic [2:0] code,
		input logic [7:0] b, input logic [7:0] c, input logic [7:0] d,
		input logic [7:0] e, input logic [7:0] h, input logic [7:0] l,
		input logic [7:0] a, input logic [7:0] m);
		logic [7:0] r;
		case (code)
			3'd0: r = b;
			3'd1: r = c;
			3'd2: r = d;
			3'd3: r = e;
			3'd4: r = h;
			3'd5: r = l;
			3'd6: r = m;
			default: r = a;
		endcase
		return r;
	endfunction

endpackage

FILE: design/e8c_cmd_if.sv
// ----------------------------------------------------------------------------
// e8c_cmd_if
// Command channel: op, address and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface e8c_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] address;
	logic [7:0]  data;

	modport source(output valid, op, address, data, input ready);
	modport sink(input valid, op, address, data, output ready);
endinterface

FILE: design/e8c_res_if.sv
// ----------------------------------------------------------------------------
// e8c_res_if
// Result channel: register snapshot and read data with valid/ready.
// ----------------------------------------------------------------------------
interface e8c_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [7:0]  acc;
	logic [7:0]  flags;
	logic [15:0] pair_bc;
	logic [15:0] pair_de;
	logic [15:0] pair_hl;
	logic [15:0] stack_ptr;
	logic [15:0] prog_counter;
	logic        halted_flag;
	logic        unknown_opcode;

	modport source(output valid, read_data, acc, flags, pair_bc, pair_de, pair_hl,
		stack_ptr, prog_counter, halted_flag, unknown_opcode, input ready);
	modport sink(input valid, read_data, acc, flags, pair_bc, pair_de, pair_hl,
		stack_ptr, prog_counter, halted_flag, unknown_opcode, output ready);
endinterface

FILE: design/e8c_front.sv
// ----------------------------------------------------------------------------
// e8c_front
// Accepts command items, classifies the op and registers them for the queue.
// ----------------------------------------------------------------------------
module e8c_front
	import e8c_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	e8c_cmd_if.sink cmd,
	output logic   item_valid,
	output item_t  item,
	input  logic   item_ready
);

	logic  v_s1;
	item_t item_s1;
	cls_t  cls;

	always_comb begin
		case (cmd.op)
			OP_WRITE: cls = CLS_WRITE;
			OP_READ:  cls = CLS_READ;
			OP_EXEC:  cls = CLS_EXEC;
			default:  cls = CLS_NONE;
		endcase
	end

	assign cmd.ready  = !v_s1 || item_ready;
	assign item_valid = v_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= '{cls: cls, address: cmd.address, data: cmd.data};
		end
	end

endmodule

FILE: design/e8c_queue.sv
// ----------------------------------------------------------------------------
// e8c_queue
// Small FIFO between the front and the execute back end.
// ----------------------------------------------------------------------------
module e8c_queue
	import e8c_pkg::*;
#(
	parameter int Depth = QDEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	item_t         store_q [Depth];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != CW'(Depth));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = store_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_q] <= push_item;
		end
	end

endmodule

FILE: design/e8c_back.sv
// ----------------------------------------------------------------------------
// e8c_back
// Instruction sequencer, register file, ALU, 64 KiB memory and result register.
// ----------------------------------------------------------------------------
module e8c_back
	import e8c_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	input  item_t    pop_item,
	output logic     pop,
	e8c_res_if.source res
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HREAD,
		S_OP,
		S_IMM1,
		S_IMM2,
		S_WR2,
		S_MEM
	} state_t;

	state_t      state_q;
	logic [15:0] clr_q;
	logic [7:0]  b_q, c_q, d_q, e_q, h_q, l_q, a_q;
	logic [3:0]  f_q;
	logic [15:0] sp_q;
	logic [15:0] pc_q;
	logic        halt_q;
	logic [7:0]  op_q;
	logic [7:0]  lo_q;
	logic [15:0] addr_q;
	logic        out_v_q;

	logic [7:0]  mem_q [65536];
	logic [7:0]  rdata_q;
	logic        mem_we;
	logic [15:0] mem_addr;
	logic [7:0]  mem_wdata;

	logic [7:0]  rd_q, acc_q, flags_q;
	logic [15:0] bc_q, de_q, hl_q, spo_q, pco_q;
	logic        hf_q, unk_q;

	logic        slot_free;
	logic        fin, fin_ex, fin_rd;

	// execute datapath
	logic [7:0]  opc;
	logic [1:0]  row;
	logic [15:0] hl, cur_p;
	logic [7:0]  src;
	logic [2:0]  kind, idc_code;
	logic        ci;
	logic [8:0]  s9;
	logic [4:0]  h5;
	logic [7:0]  ar;
	logic [7:0]  idv;
	logic [16:0] sum17;
	logic [12:0] h13;
	logic        rw_en;
	logic [2:0]  rw_code;
	logic [7:0]  rw_val;
	logic        pw_en;
	logic [1:0]  pw_sel;
	logic [15:0] pw_val;
	logic        ex_we;
	logic [15:0] ex_waddr;
	logic [7:0]  ex_wdata;
	logic [3:0]  ex_f;
	logic [15:0] ex_pc;
	logic        ex_halt, ex_unk;
	logic [7:0]  ex_b, ex_c, ex_d, ex_e, ex_h, ex_l, ex_a;

	assign opc   = (state_q == S_OP) ? rdata_q : op_q;
	assign row   = opc[5:4];
	assign hl    = {h_q, l_q};
	assign cur_p = (row == 2'd0) ? {b_q, c_q} : ((row == 2'd1) ? {d_q, e_q} : hl);
	assign src   = pick_r(opc[2:0], b_q, c_q, d_q, e_q, h_q, l_q, a_q, rdata_q);
	assign kind  = opc[5:3];
	assign idc_code = {opc[5:4], opc[3]};
	assign idv   = pick_r(idc_code, b_q, c_q, d_q, e_q, h_q, l_q, a_q, rdata_q)
		+ (opc[0] ? 8'hFF : 8'h01);
	assign sum17 = {1'b0, hl} + {1'b0, cur_p};
	assign h13   = {1'b0, hl[11:0]} + {1'b0, cur_p[11:0]};

	// 8-bit ALU
	always_comb begin
		ci = 1'b0;
		s9 = '0;
		h5 = '0;
		ar = '0;
		if (kind == ALU_ADD || kind == ALU_ADC) begin
			ci = (kind == ALU_ADC) && f_q[FC];
			s9 = {1'b0, a_q} + {1'b0, src} + {8'd0, ci};
			h5 = {1'b0, a_q[3:0]} + {1'b0, src[3:0]} + {4'd0, ci};
			ar = s9[7:0];
		end else if (kind == ALU_SUB || kind == ALU_SBC || kind == ALU_CP) begin
			ci = (kind == ALU_SBC) && f_q[FC];
			s9 = {1'b0, a_q} - {1'b0, src} - {8'd0, ci};
			h5 = {1'b0, a_q[3:0]} - {1'b0, src[3:0]} - {4'd0, ci};
			ar = s9[7:0];
		end else if (kind == ALU_AND) begin
			ar = a_q & src;
		end else if (kind == ALU_XOR) begin
			ar = a_q ^ src;
		end else begin
			ar = a_q | src;
		end
	end

	always_comb begin
		ex_f     = f_q;
		ex_pc    = pc_q;
		ex_halt  = halt_q;
		ex_unk   = 1'b0;
		rw_en    = 1'b0;
		rw_code  = idc_code;
		rw_val   = '0;
		pw_en    = 1'b0;
		pw_sel   = row;
		pw_val   = '0;
		ex_we    = 1'b0;
		ex_waddr = hl;
		ex_wdata = a_q;
		if (opc >= OPC_MAIN_LO && opc <= OPC_MAIN_HI) begin
			if (opc == OPC_HALT) begin
				ex_halt = 1'b1;
			end else if (!opc[7]) begin
				if (opc[5:3] == CODE_MEM) begin
					ex_we    = 1'b1;
					ex_wdata = src;
				end else begin
					rw_en   = 1'b1;
					rw_code = opc[5:3];
					rw_val  = src;
				end
			end else begin
				if (kind == ALU_ADD || kind == ALU_ADC) begin
					ex_f[FN] = 1'b0;
					ex_f[FH] = h5[4];
					ex_f[FC] = s9[8];
				end else if (kind == ALU_SUB || kind == ALU_SBC || kind == ALU_CP) begin
					ex_f[FN] = 1'b1;
					ex_f[FH] = h5[4];
					ex_f[FC] = s9[8];
				end else begin
					ex_f[FN] = 1'b0;
					ex_f[FH] = (kind == ALU_AND);
					ex_f[FC] = 1'b0;
				end
				ex_f[FZ] = (ar == 8'd0);
				if (kind != ALU_CP) begin
					rw_en   = 1'b1;
					rw_code = CODE_A;
					rw_val  = ar;
				end
			end
		end else if (opc >= OPC_UNK_LO) begin
			ex_unk = 1'b1;
		end else begin
			case (opc[3:0])
				4'h0: begin
					if (row == 2'd1) begin
						ex_halt = 1'b1;
					end else if (row == 2'd2 && !f_q[FZ]) begin
						ex_pc = pc_q + {{8{rdata_q[7]}}, rdata_q};
					end
				end
				4'h1: begin
					pw_en  = 1'b1;
					pw_val = {rdata_q, lo_q};
				end
				4'h2: begin
					ex_we    = 1'b1;
					ex_waddr = cur_p;
					if (row == 2'd2) begin
						pw_en  = 1'b1;
						pw_val = hl + 16'd1;
					end
				end
				4'h3: begin
					pw_en  = 1'b1;
					pw_val = cur_p + 16'd1;
				end
				4'h4, 4'h5, 4'hC, 4'hD: begin
					rw_en    = 1'b1;
					rw_val   = idv;
					ex_f[FZ] = (idv == 8'd0);
					ex_f[FN] = opc[0];
					ex_f[FH] = opc[0] ? (idv[3:0] == 4'hF) : (idv[3:0] == 4'h0);
				end
				4'h6, 4'hE: begin
					rw_en  = 1'b1;
					rw_val = rdata_q;
				end
				4'h7: begin
					if (row != 2'd2) begin
						rw_en   = 1'b1;
						rw_code = CODE_A;
						rw_val  = {a_q[6:0], (row == 2'd0) ? a_q[7] : f_q[FC]};
						ex_f    = {3'b000, a_q[7]};
					end
				end
				4'hF: begin
					if (row != 2'd2) begin
						rw_en   = 1'b1;
						rw_code = CODE_A;
						rw_val  = {(row == 2'd0) ? a_q[0] : f_q[FC], a_q[7:1]};
						ex_f    = {3'b000, a_q[0]};
					end
				end
				4'h8: begin
					if (row == 2'd1) begin
						ex_pc = pc_q + {{8{rdata_q[7]}}, rdata_q};
					end
				end
				4'h9: begin
					ex_f[FN] = 1'b0;
					ex_f[FH] = h13[12];
					ex_f[FC] = sum17[16];
					pw_en    = 1'b1;
					pw_sel   = 2'd2;
					pw_val   = sum17[15:0];
				end
				4'hA: begin
					rw_en   = 1'b1;
					rw_code = CODE_A;
					rw_val  = rdata_q;
					if (row == 2'd2) begin
						pw_en  = 1'b1;
						pw_val = hl + 16'd1;
					end
				end
				4'hB: begin
					pw_en  = 1'b1;
					pw_val = cur_p - 16'd1;
				end
				default: ;
			endcase
		end
	end

	// register write-back of the execute path
	always_comb begin
		ex_b = (rw_en && rw_code == 3'd0) ? rw_val : b_q;
		ex_c = (rw_en && rw_code == 3'd1) ? rw_val : c_q;
		ex_d = (rw_en && rw_code == 3'd2) ? rw_val : d_q;
		ex_e = (rw_en && rw_code == 3'd3) ? rw_val : e_q;
		ex_h = (rw_en && rw_code == 3'd4) ? rw_val : h_q;
		ex_l = (rw_en && rw_code == 3'd5) ? rw_val : l_q;
		ex_a = (rw_en && rw_code == CODE_A) ? rw_val : a_q;
		if (pw_en) begin
			case (pw_sel)
				2'd0: {ex_b, ex_c} = pw_val;
				2'd1: {ex_d, ex_e} = pw_val;
				default: {ex_h, ex_l} = pw_val;
			endcase
		end
	end

	assign slot_free = !out_v_q || res.ready;
	assign pop       = (state_q == S_IDLE) && pop_valid && slot_free;

	always_comb begin
		fin    = 1'b0;
		fin_ex = 1'b0;
		fin_rd = 1'b0;
		case (state_q)
			S_IDLE: fin = pop && (pop_item.cls == CLS_WRITE || pop_item.cls == CLS_NONE);
			S_HREAD: begin
				fin    = 1'b1;
				fin_rd = 1'b1;
			end
			S_OP: fin_ex = (imm_len(rdata_q) == 2'd0) && !mem_rd(rdata_q);
			S_IMM1: fin_ex = (imm_len(op_q) != 2'd2);
			S_IMM2: fin_ex = (op_q != OPC_LD_A16_SP);
			S_WR2, S_MEM: fin_ex = 1'b1;
			default: ;
		endcase
		if (fin_ex) begin
			fin = 1'b1;
		end
	end

	// single memory port
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = pc_q;
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_IDLE: begin
				if (pop && pop_item.cls == CLS_WRITE) begin
					mem_we    = 1'b1;
					mem_addr  = pop_item.address;
					mem_wdata = pop_item.data;
				end else if (pop && pop_item.cls == CLS_READ) begin
					mem_addr = pop_item.address;
				end
			end
			S_OP: begin
				if (imm_len(rdata_q) != 2'd0) begin
					mem_addr = pc_q;
				end else if (mem_rd(rdata_q)) begin
					mem_addr = (rdata_q < OPC_UNK_LO) ? cur_p : hl;
				end else if (ex_we) begin
					mem_we    = 1'b1;
					mem_addr  = ex_waddr;
					mem_wdata = ex_wdata;
				end
			end
			S_IMM2: begin
				if (op_q == OPC_LD_A16_SP) begin
					mem_we    = 1'b1;
					mem_addr  = {rdata_q, lo_q};
					mem_wdata = sp_q[7:0];
				end
			end
			S_WR2: begin
				mem_we    = 1'b1;
				mem_addr  = addr_q + 16'd1;
				mem_wdata = sp_q[15:8];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end else begin
			rdata_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			e_q     <= '0;
			h_q     <= '0;
			l_q     <= '0;
			a_q     <= '0;
			f_q     <= '0;
			sp_q    <= SP_RESET;
			pc_q    <= PC_RESET;
			halt_q  <= 1'b0;
			op_q    <= '0;
			lo_q    <= '0;
			addr_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (res.ready) begin
				out_v_q <= 1'b0;
			end
			if (fin) begin
				out_v_q <= 1'b1;
			end
			if (fin_ex) begin
				b_q    <= ex_b;
				c_q    <= ex_c;
				d_q    <= ex_d;
				e_q    <= ex_e;
				h_q    <= ex_h;
				l_q    <= ex_l;
				a_q    <= ex_a;
				f_q    <= ex_f;
				pc_q   <= ex_pc;
				halt_q <= ex_halt;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 16'd1;
					if (clr_q == 16'hFFFF) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop && pop_item.cls == CLS_READ) begin
						state_q <= S_HREAD;
					end else if (pop && pop_item.cls == CLS_EXEC) begin
						pc_q    <= pc_q + 16'd1;
						state_q <= S_OP;
					end
				end
				S_OP: begin
					op_q <= rdata_q;
					if (imm_len(rdata_q) != 2'd0) begin
						pc_q    <= pc_q + 16'd1;
						state_q <= S_IMM1;
					end else if (mem_rd(rdata_q)) begin
						state_q <= S_MEM;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_IMM1: begin
					lo_q <= rdata_q;
					if (imm_len(op_q) == 2'd2) begin
						pc_q    <= pc_q + 16'd1;
						state_q <= S_IMM2;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_IMM2: begin
					if (op_q == OPC_LD_A16_SP) begin
						addr_q  <= {rdata_q, lo_q};
						state_q <= S_WR2;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin) begin
			rd_q    <= fin_rd ? rdata_q : 8'd0;
			acc_q   <= fin_ex ? ex_a : a_q;
			flags_q <= {fin_ex ? ex_f : f_q, 4'd0};
			bc_q    <= fin_ex ? {ex_b, ex_c} : {b_q, c_q};
			de_q    <= fin_ex ? {ex_d, ex_e} : {d_q, e_q};
			hl_q    <= fin_ex ? {ex_h, ex_l} : hl;
			spo_q   <= sp_q;
			pco_q   <= fin_ex ? ex_pc : pc_q;
			hf_q    <= fin_ex ? ex_halt : halt_q;
			unk_q   <= fin_ex && ex_unk;
		end
	end

	assign res.valid          = out_v_q;
	assign res.read_data      = rd_q;
	assign res.acc            = acc_q;
	assign res.flags          = flags_q;
	assign res.pair_bc        = bc_q;
	assign res.pair_de        = de_q;
	assign res.pair_hl        = hl_q;
	assign res.stack_ptr      = spo_q;
	assign res.prog_counter   = pco_q;
	assign res.halted_flag    = hf_q;
	assign res.unknown_opcode = unk_q;

endmodule

FILE: design/eight_bit_cpu_execute_core_top.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_core_top
// SM83-subset execute core with internal 64 KiB memory.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel takes items: op 0 writes data at address, op 1 reads the byte
//   at address, op 2 steps one instruction at the program counter, op 3 only
//   reports state. res channel returns one result per item in order with the
//   register file, flags, read data, halt and unknown-opcode status.
//   Items pass a register stage and a small queue before the execute unit.
//   A step runs as opcode fetch, up to two immediate bytes, and at most one data
//   access or a second store byte, all through the single-port memory shared
//   by all accesses. Host writes sustain one item per cycle while res is not
//   stalled; a step holds the execute unit until it is done and takes no new
//   item meanwhile. After reset the memory is cleared, one byte per cycle
//   over all 65536 addresses; items are accepted into the queue meanwhile but
//   execute only afterwards. A stalled res channel holds its result; the
//   execute unit waits for the result register and cmd back-pressures once
//   the queue and the register stage fill.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_core_top
	import e8c_pkg::*;
#(
	parameter int QueueDepth = QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	e8c_cmd_if.sink   cmd,
	e8c_res_if.source res
);

	logic  f_valid, f_ready;
	item_t f_item;
	logic  q_valid, q_pop;
	item_t q_item;

	e8c_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	e8c_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop)
	);

	e8c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.pop       (q_pop),
		.res       (res)
	);

endmodule

FILE: bench/e8c_checker.sv
// ----------------------------------------------------------------------------
// e8c_checker
// Watches the cmd and res channels of the execute core, runs its own model
// of the SM83 subset on every accepted item and compares each result.
// ----------------------------------------------------------------------------
module e8c_checker
	import e8c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	e8c_cmd_if          cmd,
	e8c_res_if          res,
	output int          errors,
	output int          outstanding,
	output logic [15:0] pc_now
);

	localparam int RA = 6;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [7:0]  acc;
		logic [7:0]  flags;
		logic [15:0] pair_bc;
		logic [15:0] pair_de;
		logic [15:0] pair_hl;
		logic [15:0] stack_ptr;
		logic [15:0] prog_counter;
		logic        halted_flag;
		logic        unknown_opcode;
	} snap_t;

	logic [7:0]  mem [0:65535];
	logic [7:0]  rg [0:6];     // B C D E H L A
	logic [3:0]  fl;
	logic [15:0] sp, pc;
	logic        halt;
	snap_t       want_q [$];
	int          err_cnt;

	function automatic logic [7:0] fetch();
		logic [7:0] b;
		b = mem[pc];
		pc = pc + 16'd1;
		return b;
	endfunction

	function automatic logic [15:0] get_pair(input int p);
		return {rg[p * 2], rg[p * 2 + 1]};
	endfunction

	function automatic void set_pair(input int p, input logic [15:0] v);
		rg[p * 2] = v[15:8];
		rg[p * 2 + 1] = v[7:0];
	endfunction

	function automatic logic [7:0] get_r(input logic [2:0] code);
		if (code == CODE_MEM) return mem[get_pair(2)];
		if (code == CODE_A) return rg[RA];
		return rg[code];
	endfunction

	function automatic void set_r(input logic [2:0] code, input logic [7:0] v);
		if (code == CODE_MEM) mem[get_pair(2)] = v;
		else if (code == CODE_A) rg[RA] = v;
		else rg[code] = v;
	endfunction

	function automatic void inc_dec(input logic [2:0] code, input logic dec);
		logic [7:0] v;
		v = get_r(code) + (dec ? 8'hFF : 8'h01);
		set_r(code, v);
		fl[FZ] = (v == 8'h00);
		fl[FN] = dec;
		fl[FH] = dec ? (v[3:0] == 4'hF) : (v[3:0] == 4'h0);
	endfunction

	function automatic void add_hl(input logic [15:0] v);
		logic [15:0] hl;
		logic [16:0] s;
		logic [12:0] s12;
		hl = get_pair(2);
		s = {1'b0, hl} + {1'b0, v};
		s12 = {1'b0, hl[11:0]} + {1'b0, v[11:0]};
		fl[FN] = 1'b0;
		fl[FH] = s12[12];
		fl[FC] = s[16];
		set_pair(2, s[15:0]);
	endfunction

	function automatic void jump_rel(input logic [7:0] off);
		pc = pc + {{8{off[7]}}, off};
	endfunction

	function automatic void alu(input logic [2:0] kind, input logic [7:0] v);
		int a, c, r, ci;
		a = rg[RA];
		c = fl[FC];
		if (kind == ALU_ADD || kind == ALU_ADC) begin
			ci = (kind == ALU_ADC) ? c : 0;
			r = a + v + ci;
			fl[FN] = 1'b0;
			fl[FH] = ((a & 15) + (v & 15) + ci) > 15;
			fl[FC] = r > 255;
		end else if (kind == ALU_SUB || kind == ALU_SBC || kind == ALU_CP) begin
			ci = (kind == ALU_SBC) ? c : 0;
			r = (a - v - ci) & 255;
			fl[FN] = 1'b1;
			fl[FH] = (a & 15) < ((v & 15) + ci);
			fl[FC] = a < (v + ci);
		end else begin
			if (kind == ALU_AND) r = a & v;
			else if (kind == ALU_XOR) r = a ^ v;
			else r = a | v;
			fl[FN] = 1'b0;
			fl[FH] = (kind == ALU_AND);
			fl[FC] = 1'b0;
		end
		r = r & 255;
		fl[FZ] = (r == 0);
		if (kind != ALU_CP) rg[RA] = r[7:0];
	endfunction

	// one instruction; returns 1 for an opcode outside the subset
	function automatic logic step_cpu();
		logic [7:0]  x, lo, hi, a;
		logic [15:0] addr;
		int          row;
		x = fetch();
		if (x >= OPC_MAIN_LO && x <= OPC_MAIN_HI) begin
			if (x == OPC_HALT) halt = 1'b1;
			else if (x < 8'h80) set_r(x[5:3], get_r(x[2:0]));
			else alu(x[5:3], get_r(x[2:0]));
			return 1'b0;
		end
		if (x >= OPC_UNK_LO) return 1'b1;
		row = x[5:4];
		a = rg[RA];
		case (x[3:0])
			4'h0: begin
				if (row == 1) halt = 1'b1;
				else if (row == 2) begin
					lo = fetch();
					if (!fl[FZ]) jump_rel(lo);
				end
			end
			4'h1: begin
				lo = fetch();
				hi = fetch();
				set_pair(row, {hi, lo});
			end
			4'h2: begin
				addr = get_pair(row);
				mem[addr] = rg[RA];
				if (row == 2) set_pair(2, addr + 16'd1);
			end
			4'h3: set_pair(row, get_pair(row) + 16'd1);
			4'h4: inc_dec(3'(row * 2), 1'b0);
			4'h5: inc_dec(3'(row * 2), 1'b1);
			4'h6: rg[row * 2] = fetch();
			4'h7: begin
				// DAA in row 2 does nothing
				if (row == 0) rg[RA] = {a[6:0], a[7]};
				else if (row == 1) rg[RA] = {a[6:0], fl[FC]};
				if (row != 2) fl = {3'b000, a[7]};
			end
			4'h8: begin
				if (row == 0) begin
					lo = fetch();
					hi = fetch();
					addr = {hi, lo};
					mem[addr] = sp[7:0];
					mem[addr + 16'd1] = sp[15:8];
				end else if (row == 1) jump_rel(fetch());
				// JR Z does nothing
			end
			4'h9: add_hl(get_pair(row));
			4'hA: begin
				addr = get_pair(row);
				rg[RA] = mem[addr];
				if (row == 2) set_pair(2, addr + 16'd1);
			end
			4'hB: set_pair(row, get_pair(row) - 16'd1);
			4'hC: inc_dec(3'(row * 2 + 1), 1'b0);
			4'hD: inc_dec(3'(row * 2 + 1), 1'b1);
			4'hE: rg[row * 2 + 1] = fetch();
			default: begin
				// CPL in row 2 does nothing
				if (row == 0) rg[RA] = {a[0], a[7:1]};
				else if (row == 1) rg[RA] = {fl[FC], a[7:1]};
				if (row != 2) fl = {3'b000, a[0]};
			end
		endcase
		return 1'b0;
	endfunction

	function automatic snap_t run_item(input logic [1:0] op, input logic [15:0] addr,
		input logic [7:0] data);
		snap_t s;
		s = '0;
		if (op == OP_WRITE) mem[addr] = data;
		else if (op == OP_READ) s.read_data = mem[addr];
		else if (op == OP_EXEC) s.unknown_opcode = step_cpu();
		s.acc = rg[RA];
		s.flags = {fl, 4'h0};
		s.pair_bc = get_pair(0);
		s.pair_de = get_pair(1);
		s.pair_hl = get_pair(2);
		s.stack_ptr = sp;
		s.prog_counter = pc;
		s.halted_flag = halt;
		return s;
	endfunction

	task automatic cmp(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		snap_t w;
		if (!arst_n) begin
			for (int i = 0; i < 65536; i++) mem[i] = 8'h00;
			for (int i = 0; i < 7; i++) rg[i] = 8'h00;
			fl = 4'h0;
			sp = SP_RESET;
			pc = PC_RESET;
			halt = 1'b0;
			want_q.delete();
			err_cnt = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (want_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result with no item pending", $time);
				end else begin
					w = want_q.pop_front();
					cmp("read_data", w.read_data, res.read_data);
					cmp("acc", w.acc, res.acc);
					cmp("flags", w.flags, res.flags);
					cmp("pair_bc", w.pair_bc, res.pair_bc);
					cmp("pair_de", w.pair_de, res.pair_de);
					cmp("pair_hl", w.pair_hl, res.pair_hl);
					cmp("stack_ptr", w.stack_ptr, res.stack_ptr);
					cmp("prog_counter", w.prog_counter, res.prog_counter);
					cmp("halted_flag", w.halted_flag, res.halted_flag);
					cmp("unknown_opcode", w.unknown_opcode, res.unknown_opcode);
				end
			end
			if (cmd.valid && cmd.ready)
				want_q.push_back(run_item(cmd.op, cmd.address, cmd.data));
		end
		errors <= err_cnt;
		outstanding <= want_q.size();
		pc_now <= pc;
	end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives host writes, reads and instruction steps into the execute core,
// mostly as small programs placed at the program counter, under several
// idle and stall mixes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import e8c_pkg::*;

	localparam int TOTAL = 775;
	localparam int LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	int          errors, outstanding;
	logic [15:0] pc_now;
	int          idle_pct, stall_pct;
	int          sent, n_exec, n_host, cycle_count;

	e8c_cmd_if cmd();
	e8c_res_if res();

	eight_bit_cpu_execute_core_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res)
	);

	e8c_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.errors(errors),
		.outstanding(outstanding),
		.pc_now(pc_now)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		res.ready <= ($urandom_range(0, 99) >= stall_pct);
		if (cycle_count > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data);
		while ($urandom_range(0, 99) < idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.address <= addr;
		cmd.data <= data;
		do @(posedge clk); while (!cmd.ready);
		sent++;
		if (op == OP_EXEC) n_exec++;
		else n_host++;
		case (sent * 4 / TOTAL)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 74; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 74; end
			default: begin idle_pct = 14; stall_pct = 14; end
		endcase
	endtask

	// the last item must not stay offered while waiting
	task automatic drain();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [7:0] pick_opcode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) return $urandom_range(0, 1) ? 8'($urandom_range(8'h30, 8'h3F))
			: 8'($urandom_range(8'hC0, 8'hFF));
		if (r < 50) return 8'($urandom_range(0, 8'h2F));
		return 8'($urandom_range(OPC_MAIN_LO, OPC_MAIN_HI));
	endfunction

	initial begin
		logic [7:0]  prog [9];
		logic [15:0] p;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = OP_WRITE;
		cmd.address = '0;
		cmd.data = '0;
		res.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// SP store wrapping at 0xFFFF, stop, DAA, CPL, JR Z, unknown opcodes
		prog = '{OPC_LD_A16_SP, 8'hFF, 8'hFF, 8'h10, 8'h27, 8'h2F, 8'h28, 8'h3A, 8'hFF};
		for (int i = 0; i < 9; i++) send(OP_WRITE, PC_RESET + 16'(i), prog[i]);
		repeat (7) send(OP_EXEC, 16'h0000, 8'h00);
		send(OP_READ, 16'hFFFF, 8'hFF);
		send(OP_READ, 16'h0000, 8'h00);
		send(2'd3, 16'hFFFF, 8'hFF);
		send(OP_WRITE, 16'hFFFF, 8'hFF);
		send(OP_READ, 16'hFFFF, 8'h00);

		while (sent < TOTAL) begin
			if ($urandom_range(0, 99) < 70) begin
				drain();
				p = pc_now;
				send(OP_WRITE, p, pick_opcode());
				send(OP_WRITE, p + 16'd1, 8'($urandom));
				send(OP_WRITE, p + 16'd2, 8'($urandom));
				send(OP_EXEC, 16'($urandom), 8'($urandom));
				if ($urandom_range(0, 99) < 30) send(OP_EXEC, 16'($urandom), 8'($urandom));
			end else
				send(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Ran %0d items: %0d instruction steps, %0d host accesses,", sent, n_exec,
			n_host);
		$display("across free-running, sender-idle, receiver-stall and mixed phases.");
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
